// ===== rtl/dog_pkg.sv =====
// Shared constants and types of the departure order gate.
package dog_pkg;

    localparam int DEF_LIST_DEPTH = 16;
    localparam int DEF_ID_WIDTH   = 16;

    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int MINOCC_W = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [OP_W-1:0] OP_ARRIVE = 3'd0;
    localparam logic [OP_W-1:0] OP_DEPART = 3'd1;
    localparam logic [OP_W-1:0] OP_NODEP  = 3'd2;
    localparam logic [OP_W-1:0] OP_ASK    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_LISTED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_IGNORED  = 3'd4;

    // register select is paddr[2]
    localparam logic REG_MIN_OCC = 1'b0;
    localparam logic REG_FIFO    = 1'b1;

    typedef struct packed {
        logic [MINOCC_W-1:0] min_occ;
        logic                fifo;
    } t_cfg;

endpackage

// ===== rtl/dog_cfg.sv =====
// APB configuration registers of the departure order gate.
module dog_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dog_pkg::APB_AW-1:0]   paddr,
    input  logic [dog_pkg::APB_DW-1:0]   pwdata,
    output logic [dog_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output dog_pkg::t_cfg                o_cfg
);

    logic [dog_pkg::MINOCC_W-1:0] r_min_occ;
    logic                         r_fifo;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_occ <= '0;
            r_fifo    <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                dog_pkg::REG_MIN_OCC: r_min_occ <= pwdata[dog_pkg::MINOCC_W-1:0];
                dog_pkg::REG_FIFO:    r_fifo    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            dog_pkg::REG_MIN_OCC: prdata = dog_pkg::APB_DW'(r_min_occ);
            dog_pkg::REG_FIFO:    prdata = dog_pkg::APB_DW'(r_fifo);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.min_occ = r_min_occ;
    assign o_cfg.fifo    = r_fifo;

endmodule

// ===== rtl/dog_mem.sv =====
// Arrival list storage: one write port, one registered read port.
module dog_mem #(
    parameter int DEPTH = dog_pkg::DEF_LIST_DEPTH,
    parameter int WIDTH = dog_pkg::DEF_ID_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dog_ctrl.sv =====
// Sequencer: serial search, gap closing shift and result register.
module dog_ctrl #(
    parameter int LIST_DEPTH = dog_pkg::DEF_LIST_DEPTH,
    parameter int ID_WIDTH   = dog_pkg::DEF_ID_WIDTH,
    parameter int IDX_W      = $clog2(LIST_DEPTH),
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dog_pkg::t_cfg             i_cfg,
    input  logic                      i_s_valid,
    output logic                      o_s_ready,
    input  logic [dog_pkg::OP_W-1:0]  i_op,
    input  logic [ID_WIDTH-1:0]       i_id,
    output logic                      o_m_valid,
    input  logic                      i_m_ready,
    output logic                      o_allowed,
    output logic [dog_pkg::ST_W-1:0]  o_status,
    output logic                      o_hvalid,
    output logic [ID_WIDTH-1:0]       o_hid,
    output logic [CNT_W-1:0]          o_occ,
    output logic                      o_we,
    output logic [IDX_W-1:0]          o_waddr,
    output logic [ID_WIDTH-1:0]       o_wdata,
    output logic [IDX_W-1:0]          o_raddr,
    input  logic [ID_WIDTH-1:0]       i_rdata
);

    localparam int CMP_W = (CNT_W > dog_pkg::MINOCC_W) ? CNT_W : dog_pkg::MINOCC_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_HEAD  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [dog_pkg::OP_W-1:0] r_op, n_op;
    logic [ID_WIDTH-1:0]      r_id, n_id;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic                     r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]         r_rd_idx, n_rd_idx;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_pos, n_pos;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_pflag, n_pflag;
    logic [ID_WIDTH-1:0]      r_pid, n_pid;
    logic                     r_allowed, n_allowed;
    logic [dog_pkg::ST_W-1:0] r_status, n_status;
    logic                     r_hvalid, n_hvalid;
    logic [ID_WIDTH-1:0]      r_hid, n_hid;
    logic                     r_ovalid, n_ovalid;
    logic                     r_oallowed, n_oallowed;
    logic [dog_pkg::ST_W-1:0] r_ostatus, n_ostatus;
    logic                     r_ohvalid, n_ohvalid;
    logic [ID_WIDTH-1:0]      r_ohid, n_ohid;
    logic [CNT_W-1:0]         r_oocc, n_oocc;

    logic hit;
    logic issue;
    logic need_scan;
    logic grant;
    logic occ_met;

    assign hit       = r_rd_vld && (i_rdata == r_id);
    assign issue     = (r_ptr < r_count);
    assign occ_met   = (CMP_W'(r_count) >= CMP_W'(i_cfg.min_occ));
    assign grant     = i_cfg.fifo ? (r_pos == '0) : !(r_pflag && (r_pid != r_id));
    assign need_scan = ((i_op == dog_pkg::OP_ARRIVE) && (i_id != '0))
                    || (i_op == dog_pkg::OP_DEPART)
                    || ((i_op == dog_pkg::OP_ASK) && (i_cfg.min_occ != '0));

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_ptr      = r_ptr;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_found    = r_found;
        n_pos      = r_pos;
        n_count    = r_count;
        n_pflag    = r_pflag;
        n_pid      = r_pid;
        n_allowed  = r_allowed;
        n_status   = r_status;
        n_hvalid   = r_hvalid;
        n_hid      = r_hid;
        n_ovalid   = r_ovalid && !i_m_ready;
        n_oallowed = r_oallowed;
        n_ostatus  = r_ostatus;
        n_ohvalid  = r_ohvalid;
        n_ohid     = r_ohid;
        n_oocc     = r_oocc;
        o_we       = 1'b0;
        o_waddr    = r_count[IDX_W-1:0];
        o_wdata    = r_id;
        o_raddr    = r_ptr[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_op      = i_op;
                    n_id      = i_id;
                    n_ptr     = '0;
                    n_rd_vld  = 1'b0;
                    n_found   = 1'b0;
                    n_allowed = 1'b0;
                    n_status  = dog_pkg::ST_OK;
                    n_hvalid  = 1'b0;
                    n_hid     = '0;
                    n_state   = need_scan ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_found  = 1'b1;
                    n_pos    = r_rd_idx;
                    n_rd_vld = 1'b0;
                    n_state  = S_EXEC;
                end else if (issue) begin
                    n_ptr    = r_ptr + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    dog_pkg::OP_ARRIVE: begin
                        if (r_id == '0) begin
                            n_status = dog_pkg::ST_IGNORED;
                        end else if (r_found) begin
                            n_status = dog_pkg::ST_LISTED;
                        end else if (r_count == CNT_W'(LIST_DEPTH)) begin
                            n_status = dog_pkg::ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    dog_pkg::OP_DEPART: begin
                        n_rd_vld = 1'b0;
                        if (r_found) begin
                            n_ptr   = CNT_W'(r_pos) + CNT_W'(1);
                            n_pflag = 1'b0;
                            n_pid   = '0;
                            n_state = S_SHIFT;
                        end else begin
                            n_status = dog_pkg::ST_NOTFOUND;
                            if (i_cfg.fifo && (r_count != '0)) begin
                                n_state = S_HEAD;
                            end
                        end
                    end
                    dog_pkg::OP_NODEP: begin
                        if (!i_cfg.fifo && r_pflag && (r_pid == r_id)) begin
                            n_pflag = 1'b0;
                            n_pid   = '0;
                        end else begin
                            n_status = dog_pkg::ST_IGNORED;
                        end
                    end
                    dog_pkg::OP_ASK: begin
                        if (i_cfg.min_occ == '0) begin
                            n_allowed = 1'b1;
                        end else if (!r_found) begin
                            n_status = dog_pkg::ST_NOTFOUND;
                        end else if (occ_met) begin
                            n_allowed = grant;
                            if (grant) begin
                                n_pflag = 1'b1;
                                n_pid   = r_id;
                            end
                        end
                    end
                    dog_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = dog_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_SHIFT: begin
                // read entry k+1 while writing the word fetched before into entry k
                o_waddr = r_rd_idx - IDX_W'(1);
                o_wdata = i_rdata;
                o_we    = r_rd_vld;
                if (issue) begin
                    n_ptr    = r_ptr + CNT_W'(1);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_ptr[IDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = (i_cfg.fifo && (r_count != CNT_W'(1))) ? S_HEAD : S_DONE;
                    end
                end
            end
            S_HEAD: begin
                o_raddr = '0;
                if (!r_rd_vld) begin
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    n_hvalid = 1'b1;
                    n_hid    = i_rdata;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_ready) begin
                    n_ovalid   = 1'b1;
                    n_oallowed = r_allowed;
                    n_ostatus  = r_status;
                    n_ohvalid  = r_hvalid;
                    n_ohid     = r_hid;
                    n_oocc     = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pflag  <= 1'b0;
            r_pid    <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pflag  <= n_pflag;
            r_pid    <= n_pid;
            r_rd_vld <= n_rd_vld;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_ptr      <= n_ptr;
        r_rd_idx   <= n_rd_idx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_allowed  <= n_allowed;
        r_status   <= n_status;
        r_hvalid   <= n_hvalid;
        r_hid      <= n_hid;
        r_oallowed <= n_oallowed;
        r_ostatus  <= n_ostatus;
        r_ohvalid  <= n_ohvalid;
        r_ohid     <= n_ohid;
        r_oocc     <= n_oocc;
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_ovalid;
    assign o_allowed = r_oallowed;
    assign o_status  = r_ostatus;
    assign o_hvalid  = r_ohvalid;
    assign o_hid     = r_ohid;
    assign o_occ     = r_oocc;

endmodule

// ===== rtl/departure_order_gate.sv =====
// Departure order gate: top level with stream ports and APB configuration.
// A valid result word follows each accepted word after the serial search and
// the gap closing shift through the list memory (one entry per cycle, registered
// read port), plus any wait on the receiver. One word is in flight at a time;
// the next word is taken once the result is loaded into the output register.
// Reset: synchronous, active low; clears count, pending mark, config and FSM.
module departure_order_gate #(
    parameter int LIST_DEPTH = dog_pkg::DEF_LIST_DEPTH,
    parameter int ID_WIDTH   = dog_pkg::DEF_ID_WIDTH,
    localparam int IDX_W     = $clog2(LIST_DEPTH),
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
    localparam int IN_W      = ((dog_pkg::OP_W + ID_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS  = 2 + dog_pkg::ST_W + ID_WIDTH + CNT_W,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode, vehicle_id
    input  logic [IN_W-1:0]             s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // allowed, status, head_valid, head_id, occupancy
    output logic [OUT_W-1:0]            m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dog_pkg::APB_AW-1:0]  paddr,
    input  logic [dog_pkg::APB_DW-1:0]  pwdata,
    output logic [dog_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    dog_pkg::t_cfg            cfg;
    logic                     allowed;
    logic [dog_pkg::ST_W-1:0] status;
    logic                     hvalid;
    logic [ID_WIDTH-1:0]      hid;
    logic [CNT_W-1:0]         occ;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic [ID_WIDTH-1:0]      wdata;
    logic [IDX_W-1:0]         raddr;
    logic [ID_WIDTH-1:0]      rdata;

    dog_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dog_mem #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dog_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_op      (s_axis_tdata[dog_pkg::OP_W-1:0]),
        .i_id      (s_axis_tdata[dog_pkg::OP_W+ID_WIDTH-1:dog_pkg::OP_W]),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_allowed (allowed),
        .o_status  (status),
        .o_hvalid  (hvalid),
        .o_hid     (hid),
        .o_occ     (occ),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata)
    );

    assign m_axis_tdata = OUT_W'({occ, hid, hvalid, status, allowed});

endmodule

// ===== rtl/dog_chk.sv =====
// Port level checker of the departure order gate, bound to the top level.
module dog_chk #(
    parameter int LIST_DEPTH = dog_pkg::DEF_LIST_DEPTH,
    parameter int ID_WIDTH   = dog_pkg::DEF_ID_WIDTH,
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1),
    localparam int OUT_BITS  = 2 + dog_pkg::ST_W + ID_WIDTH + CNT_W,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8,
    localparam int OCC_LO    = 2 + dog_pkg::ST_W + ID_WIDTH
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic                     allowed;
    logic [dog_pkg::ST_W-1:0] status;
    logic                     hvalid;
    logic [CNT_W-1:0]         occ;

    assign allowed = m_axis_tdata[0];
    assign status  = m_axis_tdata[dog_pkg::ST_W:1];
    assign hvalid  = m_axis_tdata[dog_pkg::ST_W+1];
    assign occ     = m_axis_tdata[OCC_LO+CNT_W-1:OCC_LO];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in work");

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> CNT_W'(occ) <= CNT_W'(LIST_DEPTH))
        else $error("occupancy beyond list depth");

    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && allowed |-> status == dog_pkg::ST_OK && !hvalid)
        else $error("grant with bad status or head report");

    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && hvalid |->
            (status == dog_pkg::ST_OK || status == dog_pkg::ST_NOTFOUND) && occ != '0)
        else $error("head report on empty list or wrong status");

endmodule

bind departure_order_gate dog_chk #(
    .LIST_DEPTH (LIST_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
) u_dog_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
